>>> rtl/ekiq_pkg.sv
// ----------------------------------------------------------------------------
// ekiq_pkg
// Shared types and constants for the encoder key input queue.
// ----------------------------------------------------------------------------
package ekiq_pkg;

    // Item opcodes.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    // Key codes.
    localparam logic [1:0] KEY_UP     = 2'd0;
    localparam logic [1:0] KEY_DOWN   = 2'd1;
    localparam logic [1:0] KEY_SELECT = 2'd2;

    // Encoder A/B pairs, written as {a, b}.
    localparam logic [1:0] AB_PREV_UP   = 2'b00;
    localparam logic [1:0] AB_CUR_UP    = 2'b10;
    localparam logic [1:0] AB_PREV_DOWN = 2'b01;
    localparam logic [1:0] AB_CUR_DOWN  = 2'b11;

    localparam int unsigned DEB_W = 8;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd10;

    typedef logic [1:0] t_key;

    // Request from the execute stage to the queue.
    typedef struct packed {
        logic push;
        logic pop;
        t_key key;
    } t_q_req;

    // Queue status back to the execute stage.
    typedef struct packed {
        logic full;
        logic empty;
        t_key head;
    } t_q_stat;

endpackage

>>> rtl/ekiq_if.sv
// ----------------------------------------------------------------------------
// ekiq_in_if / ekiq_out_if
// Valid/ready channels that carry input items and result items.
// ----------------------------------------------------------------------------
interface ekiq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       switch_level;
    logic       cur_a;
    logic       cur_b;
    logic       prev_a;
    logic       prev_b;

    modport source (output valid, opcode, switch_level, cur_a, cur_b, prev_a, prev_b,
                    input ready);
    modport sink   (input valid, opcode, switch_level, cur_a, cur_b, prev_a, prev_b,
                    output ready);
endinterface

interface ekiq_out_if;
    logic       valid;
    logic       ready;
    logic       key_valid;
    logic [1:0] key_code;
    logic       key_dropped;

    modport source (output valid, key_valid, key_code, key_dropped, input ready);
    modport sink   (input valid, key_valid, key_code, key_dropped, output ready);
endinterface

>>> rtl/ekiq_debounce.sv
// ----------------------------------------------------------------------------
// ekiq_debounce
// Push switch debouncer with its configuration register.
// ----------------------------------------------------------------------------
module ekiq_debounce (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [ekiq_pkg::DEB_W-1:0] i_cfg_wdata,
    input  logic                     i_tick,
    input  logic                     i_level,
    output logic                     o_press
);

    logic [ekiq_pkg::DEB_W-1:0] r_ticks;
    logic [ekiq_pkg::DEB_W-1:0] r_count;
    logic [ekiq_pkg::DEB_W-1:0] n_count;
    logic                       r_pressed;
    logic                       n_pressed;
    logic                       pressed;

    // The pin is active low.
    assign pressed = ~i_level;

    always_comb begin
        n_count   = r_count;
        n_pressed = r_pressed;
        o_press   = 1'b0;
        if (i_tick) begin
            if (pressed == r_pressed) begin
                n_count = '0;
            end else if (r_count == '0) begin
                n_count = r_ticks;
            end else begin
                n_count = r_count - 1'b1;
                if (r_count == ekiq_pkg::DEB_W'(1)) begin
                    n_pressed = pressed;
                    o_press   = pressed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= ekiq_pkg::DEBOUNCE_RESET;
            r_count   <= '0;
            r_pressed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ticks <= i_cfg_wdata;
            end
            r_count   <= n_count;
            r_pressed <= n_pressed;
        end
    end

endmodule

>>> rtl/ekiq_queue.sv
// ----------------------------------------------------------------------------
// ekiq_queue
// Circular key queue that keeps one slot empty, with a registered head read.
// ----------------------------------------------------------------------------
module ekiq_queue #(
    parameter int unsigned DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ekiq_pkg::t_q_req i_req,
    output ekiq_pkg::t_q_stat o_stat
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    ekiq_pkg::t_key mem [DEPTH];

    logic [IDX_W-1:0] r_wr;
    logic [IDX_W-1:0] r_rd;
    logic [IDX_W-1:0] n_wr;
    logic [IDX_W-1:0] n_rd;
    logic [IDX_W-1:0] wr_next;
    logic [IDX_W-1:0] rd_next;
    ekiq_pkg::t_key   r_head;
    logic             full;
    logic             empty;
    logic             wr_en;
    logic             rd_en;

    assign wr_next = (r_wr == LAST) ? '0 : r_wr + 1'b1;
    assign rd_next = (r_rd == LAST) ? '0 : r_rd + 1'b1;
    assign full    = (wr_next == r_rd);
    assign empty   = (r_wr == r_rd);
    assign wr_en   = i_req.push & ~full;
    assign rd_en   = i_req.pop & ~empty;
    assign n_wr    = wr_en ? wr_next : r_wr;
    assign n_rd    = rd_en ? rd_next : r_rd;

    assign o_stat.full  = full;
    assign o_stat.empty = empty;
    assign o_stat.head  = r_head;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wr] <= i_req.key;
        end
        // Head entry for the next cycle; a key written to that slot right now
        // is forwarded.
        if (wr_en && (r_wr == n_rd)) begin
            r_head <= i_req.key;
        end else begin
            r_head <= mem[n_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

endmodule

>>> rtl/encoder_key_input_queue_unit.sv
// ----------------------------------------------------------------------------
// encoder_key_input_queue_unit
// Rotary encoder and push switch to key code queue.
// ----------------------------------------------------------------------------
// Every accepted transaction yields exactly one result transaction. A new
// input transaction can be taken on every clock while the result channel
// applies no back pressure. An accepted transaction is held in the input
// register, executed and loaded into the result register, and is offered on
// the result channel from then on. The sustained rate is one transaction
// per clock, set by the single execute stage between those two registers,
// while the result channel takes every result. The queue memory is written
// at the write pointer and read at the read pointer with a registered head
// entry, so pushes and pops both complete within the execute stage. Back
// pressure on the result channel stalls the execute stage and then the input
// register. The debounce period is written through i_cfg_we and i_cfg_wdata;
// the user must do so only while no transaction is in flight, and the block
// does not enforce this. The period resets to 10 ticks.
// ----------------------------------------------------------------------------
module encoder_key_input_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ekiq_pkg::DEB_W-1:0] i_cfg_wdata,
    ekiq_in_if.sink                    i_item,
    ekiq_out_if.source                 o_result
);

    // Input register.
    logic       r_in_valid;
    logic [1:0] r_opcode;
    logic       r_switch_level;
    logic [1:0] r_cur;
    logic [1:0] r_prev;

    // Result register.
    logic       r_out_valid;
    logic       r_key_valid;
    logic [1:0] r_key_code;
    logic       r_key_dropped;

    logic              out_free;
    logic              exec;
    logic              in_take;
    logic              is_tick;
    logic              is_pop;
    logic              enc_up;
    logic              enc_down;
    logic              press;
    ekiq_pkg::t_q_req  q_req;
    ekiq_pkg::t_q_stat q_stat;
    logic              n_key_valid;

    // The execute stage runs when it holds a transaction and the result
    // register is empty or being drained this cycle.
    assign out_free     = ~r_out_valid | o_result.ready;
    assign exec         = r_in_valid & out_free;
    assign i_item.ready = ~r_in_valid | exec;
    assign in_take      = i_item.valid & i_item.ready;

    assign is_tick  = exec & (r_opcode == ekiq_pkg::OP_TICK);
    assign is_pop   = exec & (r_opcode == ekiq_pkg::OP_POP);
    assign enc_up   = exec & (r_opcode == ekiq_pkg::OP_SAMPLE)
                      & (r_prev == ekiq_pkg::AB_PREV_UP) & (r_cur == ekiq_pkg::AB_CUR_UP);
    assign enc_down = exec & (r_opcode == ekiq_pkg::OP_SAMPLE)
                      & (r_prev == ekiq_pkg::AB_PREV_DOWN)
                      & (r_cur == ekiq_pkg::AB_CUR_DOWN);

    ekiq_debounce u_debounce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tick      (is_tick),
        .i_level     (r_switch_level),
        .o_press     (press)
    );

    // At most one key source is active for a given transaction.
    always_comb begin
        q_req.push = press | enc_up | enc_down;
        q_req.pop  = is_pop;
        if (press) begin
            q_req.key = ekiq_pkg::KEY_SELECT;
        end else if (enc_up) begin
            q_req.key = ekiq_pkg::KEY_UP;
        end else begin
            q_req.key = ekiq_pkg::KEY_DOWN;
        end
    end

    ekiq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .o_stat  (q_stat)
    );

    assign n_key_valid = is_pop & ~q_stat.empty;

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode       <= i_item.opcode;
            r_switch_level <= i_item.switch_level;
            r_cur          <= {i_item.cur_a, i_item.cur_b};
            r_prev         <= {i_item.prev_a, i_item.prev_b};
        end
        if (exec) begin
            r_key_valid   <= n_key_valid;
            r_key_code    <= n_key_valid ? q_stat.head : ekiq_pkg::KEY_UP;
            r_key_dropped <= q_req.push & q_stat.full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.key_valid   = r_key_valid;
    assign o_result.key_code    = r_key_code;
    assign o_result.key_dropped = r_key_dropped;

endmodule
